// ===== hw/rtl/sorted_set_insert_defines.svh =====
// ---------------------------------------------------------------------------
// Sorted set insert assertion macros
// Shared concurrent assertion forms for the sorted set insert block.
// ---------------------------------------------------------------------------
`ifndef SORTED_SET_INSERT_DEFINES_SVH
`define SORTED_SET_INSERT_DEFINES_SVH

// Asserts that a condition holds at every clock edge outside reset.
`define SSI_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Asserts that a consequent holds in the cycle after an antecedent.
`define SSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ssi_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted set insert package
// Types and constants shared by the sorted set insert cells and top level.
// ---------------------------------------------------------------------------
package ssi_pkg;

  localparam int unsigned CapacityDefault = 32;
  localparam int unsigned CodeW           = 10;
  localparam int unsigned KindW           = 2;
  localparam int unsigned StatusW         = 3;

  typedef enum logic [KindW-1:0] {
    KindInsert = 2'd0,
    KindDump   = 2'd1,
    KindClear  = 2'd2,
    KindNone   = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StatusInserted  = 3'd0,
    StatusDuplicate = 3'd1,
    StatusFull      = 3'd2,
    StatusEntry     = 3'd3,
    StatusEmpty     = 3'd4,
    StatusCleared   = 3'd5
  } status_e;

  typedef enum logic {
    StIdle = 1'b0,
    StDump = 1'b1
  } state_e;

  typedef struct packed {
    logic ins;
    logic rot;
    logic occ;
    logic tail;
    logic slot;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/ssi_cell.sv =====
// ---------------------------------------------------------------------------
// Sorted set insert cell
// Holds one stored code, compares it with the incoming code, and shifts
// toward its upper neighbor on insert or toward its lower neighbor on dump.
// ---------------------------------------------------------------------------
module ssi_cell
  import ssi_pkg::*;
(
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CodeW-1:0] code_i,
  input  logic [CodeW-1:0] prev_value_i,
  input  logic             prev_ge_i,
  input  logic [CodeW-1:0] next_value_i,
  input  logic [CodeW-1:0] wrap_value_i,
  output logic [CodeW-1:0] value_o,
  output logic             ge_o,
  output logic             eq_o
);

  logic [CodeW-1:0] value_q;
  logic [CodeW-1:0] value_d;

  assign ge_o    = ctrl_i.occ && (value_q >= code_i);
  assign eq_o    = ctrl_i.occ && (value_q == code_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (prev_ge_i) begin
        value_d = prev_value_i;
      end else if (ge_o || ctrl_i.slot) begin
        value_d = code_i;
      end
    end else if (ctrl_i.rot) begin
      value_d = ctrl_i.tail ? wrap_value_i : next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== hw/rtl/sorted_set_insert.sv =====
// ---------------------------------------------------------------------------
// Sorted set insert
// Bounded store of codes kept in ascending order without repeats.
// ---------------------------------------------------------------------------
// An insert or clear word is taken while busy_o is low and its single result appears
// on the next cycle; busy_o stays low, so such words may be issued every
// cycle. A dump of N stored codes keeps busy_o high while the cell row
// rotates one position per cycle, presenting the smallest code first;
// a dump of an empty store gives one result on the next cycle. Every result is
// shown for exactly one cycle with valid_o high and cannot be held off, so the
// receiver must take it in that cycle. The row of CAPACITY compare cells
// sets the insert rate of one word per cycle while busy_o is low.
`include "sorted_set_insert_defines.svh"

module sorted_set_insert
  import ssi_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [CodeW-1:0]   code_value_i,
  output logic               valid_o,
  output logic [StatusW-1:0] status_o,
  output logic [CodeW-1:0]   entry_value_o,
  output logic               last_entry_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  dump_q, dump_d;
  logic             valid_q, valid_d;
  status_e          status_q, status_d;
  logic [CodeW-1:0] entry_q, entry_d;
  logic             last_q, last_d;

  logic [CodeW-1:0] cell_value [CAPACITY];
  logic [CodeW-1:0] prev_value [CAPACITY];
  logic [CodeW-1:0] next_value [CAPACITY];
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] prev_ge;
  cell_ctrl_t       ctrl [CAPACITY];

  logic accept;
  logic dup;
  logic full;
  logic ins_ok;
  logic dump_last;

  assign busy_o    = (state_q == StDump);
  assign accept    = start_i && !busy_o;
  assign dup       = |eq;
  assign full      = (count_q == CntW'(CAPACITY));
  assign ins_ok    = accept && (kind_e'(kind_i) == KindInsert) && !dup && !full;
  assign dump_last = ((dump_q + 1'b1) == count_q);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_value[i] = code_value_i;
      assign prev_ge[i]    = 1'b0;
    end else begin : g_inner
      assign prev_value[i] = cell_value[i-1];
      assign prev_ge[i]    = ge[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign next_value[i] = cell_value[0];
    end else begin : g_mid
      assign next_value[i] = cell_value[i+1];
    end

    assign ctrl[i].ins  = ins_ok;
    assign ctrl[i].rot  = busy_o;
    assign ctrl[i].occ  = (CntW'(i) < count_q);
    assign ctrl[i].tail = (CntW'(i + 1) == count_q);
    assign ctrl[i].slot = (CntW'(i) == count_q);

    ssi_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[i]),
      .code_i       (code_value_i),
      .prev_value_i (prev_value[i]),
      .prev_ge_i    (prev_ge[i]),
      .next_value_i (next_value[i]),
      .wrap_value_i (cell_value[0]),
      .value_o      (cell_value[i]),
      .ge_o         (ge[i]),
      .eq_o         (eq[i])
    );
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    dump_d   = dump_q;
    valid_d  = 1'b0;
    status_d = status_q;
    entry_d  = entry_q;
    last_d   = last_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (kind_e'(kind_i))
            KindInsert: begin
              valid_d = 1'b1;
              entry_d = code_value_i;
              last_d  = 1'b1;
              if (dup) begin
                status_d = StatusDuplicate;
              end else if (full) begin
                status_d = StatusFull;
              end else begin
                status_d = StatusInserted;
                count_d  = count_q + 1'b1;
              end
            end
            KindDump: begin
              if (count_q == '0) begin
                valid_d  = 1'b1;
                status_d = StatusEmpty;
                entry_d  = code_value_i;
                last_d   = 1'b1;
              end else begin
                state_d = StDump;
                dump_d  = '0;
              end
            end
            KindClear: begin
              count_d  = '0;
              valid_d  = 1'b1;
              status_d = StatusCleared;
              entry_d  = code_value_i;
              last_d   = 1'b1;
            end
            KindNone: begin
            end
            default: begin
            end
          endcase
        end
      end
      StDump: begin
        valid_d  = 1'b1;
        status_d = StatusEntry;
        entry_d  = cell_value[0];
        last_d   = dump_last;
        dump_d   = dump_q + 1'b1;
        if (dump_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      dump_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      dump_q  <= dump_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    entry_q  <= entry_d;
    last_q   <= last_d;
  end

  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign entry_value_o = entry_q;
  assign last_entry_o  = last_q;

  `SSI_ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(CAPACITY), "Entry count exceeds capacity.")
  `SSI_ASSERT_ALWAYS(a_busy_nonempty, !busy_o || (count_q != '0), "Dump runs on an empty store.")
  `SSI_ASSERT_NEXT(a_dump_ends, busy_o && dump_last, !busy_o && valid_o && last_entry_o, "Dump did not end on its last entry.")
  `SSI_ASSERT_NEXT(a_dup_keeps, accept && (kind_e'(kind_i) == KindInsert) && dup, $stable(count_q) && (status_o == StatusDuplicate), "Duplicate insert changed the store.")

endmodule

// ===== tb/tb_sorted_set_insert.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted set insert testbench
// Sends insert, dump, clear and unused words through the start/busy port. A
// shadow copy of the sorted store predicts every result. Each strobed result
// is compared field by field with the oldest prediction. The tests cover the
// empty store, the code extremes, a full store and random traffic with and
// without gaps between words.
// ---------------------------------------------------------------------------
module tb_sorted_set_insert;
  import ssi_pkg::*;

  localparam int unsigned Capacity   = CapacityDefault;
  localparam int unsigned CodeMax    = (1 << CodeW) - 1;
  localparam int unsigned StallLimit = 400;
  localparam int unsigned DrainLimit = 2000;
  localparam int unsigned DrainTail  = Capacity + 8;
  localparam realtime     ClkHalf    = 6ns;

  typedef struct {
    status_e          status;
    logic [CodeW-1:0] value;
    logic             last;
  } outcome_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               start_i      = 1'b0;
  logic [KindW-1:0]   kind_i       = KindInsert;
  logic [CodeW-1:0]   code_value_i = '0;
  logic               busy_o;
  logic               valid_o;
  logic [StatusW-1:0] status_o;
  logic [CodeW-1:0]   entry_value_o;
  logic               last_entry_o;

  logic [CodeW-1:0] shadow_codes [Capacity];
  int unsigned      shadow_count = 0;
  outcome_t         pending_outcomes [$];
  int unsigned      fail_count = 0;

  sorted_set_insert #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .kind_i       (kind_i),
    .code_value_i (code_value_i),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .entry_value_o(entry_value_o),
    .last_entry_o (last_entry_o)
  );

  always begin
    #(ClkHalf) clk_i = 1'b1;
    #(ClkHalf) clk_i = 1'b0;
  end

  function automatic outcome_t make_outcome(status_e status, logic [CodeW-1:0] value,
                                            logic last);
    outcome_t o;
    o.status = status;
    o.value  = value;
    o.last   = last;
    return o;
  endfunction

  task automatic predict_outcome(kind_e kind, logic [CodeW-1:0] code);
    int unsigned pos;
    status_e     status;
    case (kind)
      KindInsert: begin
        pos = 0;
        while (pos < shadow_count && code > shadow_codes[pos]) pos++;
        if (pos < shadow_count && shadow_codes[pos] == code) begin
          status = StatusDuplicate;
        end else if (shadow_count >= Capacity) begin
          status = StatusFull;
        end else begin
          for (int i = shadow_count; i > pos; i--) shadow_codes[i] = shadow_codes[i-1];
          shadow_codes[pos] = code;
          shadow_count++;
          status = StatusInserted;
        end
        pending_outcomes.push_back(make_outcome(status, code, 1'b1));
      end
      KindDump: begin
        if (shadow_count == 0) begin
          pending_outcomes.push_back(make_outcome(StatusEmpty, code, 1'b1));
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            pending_outcomes.push_back(make_outcome(StatusEntry, shadow_codes[i],
                                                    (i + 1 == shadow_count)));
          end
        end
      end
      KindClear: begin
        shadow_count = 0;
        pending_outcomes.push_back(make_outcome(StatusCleared, code, 1'b1));
      end
      default: begin
      end
    endcase
  endtask

  // Called at a rising edge; returns at the edge that accepts the word.
  task automatic send_word(kind_e kind, logic [CodeW-1:0] code);
    start_i      <= 1'b1;
    kind_i       <= kind;
    code_value_i <= code;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_outcome(kind, code);
  endtask

  task automatic idle_burst();
    start_i <= 1'b0;
    repeat ($urandom_range(1, 13)) @(posedge clk_i);
  endtask

  task automatic send_random_word(bit allow_idle);
    int unsigned      pick;
    kind_e            kind;
    logic [CodeW-1:0] code;
    pick = $urandom_range(0, 99);
    code = CodeW'($urandom_range(0, CodeMax));
    if (pick < 82) begin
      kind = KindInsert;
      if ($urandom_range(0, 1) == 0) code = CodeW'($urandom_range(0, 63));
    end else if (pick < 94) begin
      kind = KindDump;
    end else if (pick < 97) begin
      kind = KindClear;
    end else begin
      kind = KindNone;
    end
    if (allow_idle && $urandom_range(0, 3) == 0) idle_burst();
    send_word(kind, code);
  endtask

  task automatic test_empty_store();
    send_word(KindDump, CodeW'(CodeMax));
    send_word(KindClear, '0);
    send_word(KindNone, CodeW'($urandom_range(0, CodeMax)));
    send_word(KindDump, CodeW'(341));
  endtask

  task automatic test_extremes_and_order();
    send_word(KindInsert, CodeW'(500));
    send_word(KindInsert, '0);
    send_word(KindInsert, CodeW'(CodeMax));
    send_word(KindInsert, CodeW'(999));
    send_word(KindInsert, CodeW'(1000));
    send_word(KindInsert, CodeW'(1));
    send_word(KindInsert, CodeW'(682));
    send_word(KindInsert, CodeW'(500));
    send_word(KindInsert, '0);
    send_word(KindInsert, CodeW'(CodeMax));
    send_word(KindNone, CodeW'(200));
    send_word(KindDump, CodeW'(682));
    send_word(KindClear, CodeW'(999));
    send_word(KindDump, '0);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < Capacity; i++) send_word(KindInsert, CodeW'(CodeMax - i * 32));
    send_word(KindInsert, CodeW'(500));
    send_word(KindInsert, CodeW'(CodeMax - 16 * 32));
    send_word(KindInsert, '0);
    send_word(KindInsert, CodeW'(CodeMax));
    send_word(KindDump, CodeW'(77));
    send_word(KindClear, CodeW'(555));
  endtask

  task automatic test_random_traffic(int unsigned count);
    for (int i = 0; i < count; i++) send_random_word(1'b1);
  endtask

  task automatic test_back_to_back(int unsigned count);
    for (int i = 0; i < count; i++) send_random_word(1'b0);
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result word: status %0d entry_value %0d last_entry %0b",
               status_o, entry_value_o, last_entry_o);
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.status) begin
          $error("status expected %0d actual %0d", want.status, status_o);
          fail_count++;
        end
        if (entry_value_o !== want.value) begin
          $error("entry_value expected %0d actual %0d", want.value, entry_value_o);
          fail_count++;
        end
        if (last_entry_o !== want.last) begin
          $error("last_entry expected %0b actual %0b", want.last, last_entry_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    wait (rst_ni === 1'b1);
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || valid_o === 1'b1) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("FAIL sorted_set_insert");
    $finish;
  end

  initial begin
    int unsigned drain_cycles;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_empty_store();
    test_extremes_and_order();
    test_full_store();
    test_random_traffic(150);
    test_back_to_back(50);

    start_i <= 1'b0;
    drain_cycles = 0;
    while (pending_outcomes.size() != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (DrainTail) @(posedge clk_i);
    if (pending_outcomes.size() != 0) begin
      $error("%0d expected result words never arrived", pending_outcomes.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("PASS sorted_set_insert");
    end else begin
      $display("FAIL sorted_set_insert");
    end
    $finish;
  end

endmodule
